// ===== src/ipp_pkg.sv =====
`default_nettype none
package ipp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
  localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

  typedef enum logic [2:0] {
    PH_PARSE  = 3'd0,
    PH_SKIP   = 3'd1,
    PH_TSTART = 3'd2,
    PH_TWS    = 3'd3,
    PH_TDIG   = 3'd4,
    PH_DONE   = 3'd5,
    PH_FAIL   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [31:0]       v4_octets;
    logic [2:0]        v4_cnt;
    logic [8:0]        v4_acc;
    phase_t            v4_ph;
    logic [7:0]        v4_pre;
    logic [7:0][15:0]  v6_front;
    logic [7:0][15:0]  v6_back;   // newest group at index 0
    logic [3:0]        v6_fcnt;
    logic [3:0]        v6_bcnt;
    logic              v6_dc;
    logic [16:0]       v6_acc;
    phase_t            v6_ph;
    logic [7:0]        v6_pre;
    logic              first;
  } ipp_state_t;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } text_t;

  typedef struct packed {
    logic        valid_res;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  prefix_length;
  } result_t;

endpackage
`default_nettype wire

// ===== src/ip_address_text_parser.sv =====
`default_nettype none
// Channel  Direction  Handshake                  Beat
// text     in         text_valid / text_stall    character, end_of_text
// result   out        result_valid / result_stall valid_res, is_ipv6, address, prefix
//
// One text beat is taken per cycle while text_stall is low. A beat with end_of_text produces one result
// beat in the next cycle; the last character and the two-character lookahead are
// worked through in the cycle that takes that beat by a chain of four character steps.
// Reset (rst, synchronous) empties the lookahead and clears all parse state.
// Only a final beat waits while a result is held in the output register.
module ip_address_text_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_stall,
  input  ipp_pkg::text_t   text,
  output logic             result_valid,
  input  logic             result_stall,
  output ipp_pkg::result_t result
);
  import ipp_pkg::*;

  logic [7:0] la0;
  logic [7:0] la1;
  logic [1:0] la_cnt;
  logic       saw_colon;
  logic       saw_dot;
  ipp_state_t st;

  ipp_state_t rst_state;
  ipp_state_t chain [0:4];
  logic [7:0] s [0:3];
  logic       accept;
  logic       end_acc;
  logic       colon_n;
  logic       dot_n;
  ipp_state_t fin;
  result_t    res_next;

  always_comb begin
    rst_state = '0;
    rst_state.v4_ph = PH_PARSE;
    rst_state.v6_ph = PH_PARSE;
    rst_state.first = 1'b1;
  end

  assign text_stall = text.end_of_text && result_valid && result_stall;
  assign accept = text_valid && !text_stall;
  assign end_acc = accept && text.end_of_text;

  // Character sequence with zero padding after the last character.
  always_comb begin
    s[0] = (la_cnt == 2'd0) ? text.character : la0;
    s[1] = (la_cnt == 2'd0) ? CH_NUL : ((la_cnt == 2'd1) ? text.character : la1);
    s[2] = (la_cnt == 2'd2) ? text.character : CH_NUL;
    s[3] = CH_NUL;
  end

  assign chain[0] = st;
  ipp_step u_step0 (.cur(chain[0]), .c(s[0]), .l1(s[1]), .l2(s[2]), .nxt(chain[1]));
  ipp_step u_step1 (.cur(chain[1]), .c(s[1]), .l1(s[2]), .l2(s[3]), .nxt(chain[2]));
  ipp_step u_step2 (.cur(chain[2]), .c(s[2]), .l1(s[3]), .l2(CH_NUL), .nxt(chain[3]));
  ipp_step u_step3 (.cur(chain[3]), .c(s[3]), .l1(CH_NUL), .l2(CH_NUL), .nxt(chain[4]));

  assign colon_n = saw_colon || (text.character == CH_COLON);
  assign dot_n = saw_dot || (text.character == CH_DOT);

  always_comb begin
    logic [7:0][15:0] g;
    logic [7:0]       pre;
    logic [7:0]       maxp;
    logic             ok;

    case (la_cnt)
      2'd0:    fin = chain[2];
      2'd1:    fin = chain[3];
      default: fin = chain[4];
    endcase

    for (int j = 0; j < 8; j++) begin
      g[j] = 16'd0;
      if (4'(j) < fin.v6_fcnt) g[j] = fin.v6_front[j];
      if (4'(7 - j) < fin.v6_bcnt) g[j] = fin.v6_back[7 - j];
    end

    res_next = '0;
    if (colon_n) begin
      ok = (fin.v6_ph == PH_DONE);
      maxp = V6_MAX_PREFIX;
      pre = fin.v6_pre;
      res_next.address_high = {g[0], g[1], g[2], g[3]};
      res_next.address_low = {g[4], g[5], g[6], g[7]};
      res_next.is_ipv6 = 1'b1;
    end else begin
      ok = dot_n && (fin.v4_ph == PH_DONE);
      maxp = V4_MAX_PREFIX;
      pre = fin.v4_pre;
      res_next.address_high = {fin.v4_octets, 32'd0};
    end
    if (pre == 8'd0 || pre > maxp) pre = maxp;
    res_next.prefix_length = pre;
    res_next.valid_res = ok;
    if (!ok) res_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      la0 <= CH_NUL;
      la1 <= CH_NUL;
      la_cnt <= 2'd0;
      saw_colon <= 1'b0;
      saw_dot <= 1'b0;
      st <= rst_state;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !end_acc) result_valid <= 1'b0;
      if (accept) begin
        if (text.end_of_text) begin
          la_cnt <= 2'd0;
          saw_colon <= 1'b0;
          saw_dot <= 1'b0;
          st <= rst_state;
          result_valid <= 1'b1;
        end else begin
          saw_colon <= colon_n;
          saw_dot <= dot_n;
          case (la_cnt)
            2'd0: begin
              la0 <= text.character;
              la_cnt <= 2'd1;
            end
            2'd1: begin
              la1 <= text.character;
              la_cnt <= 2'd2;
            end
            default: begin
              st <= chain[1];
              la0 <= la1;
              la1 <= text.character;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (end_acc) result <= res_next;
  end

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    end_acc |=> result_valid)
    else $error("final beat did not produce a result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.valid_res) |->
      (result.prefix_length == 8'd0 && !result.is_ipv6))
    else $error("invalid result carries nonzero fields");

  a_v4_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.valid_res && !result.is_ipv6) |->
      (result.address_low == 64'd0 && result.prefix_length <= V4_MAX_PREFIX &&
       result.prefix_length != 8'd0))
    else $error("IPv4 result out of shape");

  a_lookahead: assert property (@(posedge clk) disable iff (rst)
    la_cnt != 2'd3)
    else $error("lookahead count overran");

endmodule
`default_nettype wire

// ===== src/ipp_step.sv =====
`default_nettype none
module ipp_step (
  input  ipp_pkg::ipp_state_t cur,
  input  logic [7:0]          c,
  input  logic [7:0]          l1,
  input  logic [7:0]          l2,
  output ipp_pkg::ipp_state_t nxt
);
  import ipp_pkg::*;

  typedef struct packed {
    phase_t     ph;
    logic [7:0] acc;
  } tail_t;

  function automatic logic is_dec(logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  function automatic logic is_space(logic [7:0] ch);
    return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_val(logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (is_dec(ch)) r = {1'b1, ch[3:0]};
    else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
      r = {1'b1, ch[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic [7:0] acc_prefix(logic [7:0] a, logic [7:0] ch);
    logic [11:0] v;
    v = {4'b0, a} * 12'd10 + {8'b0, ch[3:0]};
    return (v > 12'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic tail_t tail_step(phase_t ph, logic [7:0] acc, logic [7:0] ch);
    tail_t t;
    t.ph = ph;
    t.acc = acc;
    case (ph)
      PH_TSTART: begin
        if (ch == CH_NUL) begin
          t.acc = 8'd0;
          t.ph = PH_DONE;
        end else begin
          t.ph = (ch == CH_SLASH) ? PH_TWS : PH_FAIL;
        end
      end
      PH_TWS: begin
        if (is_space(ch)) t.ph = PH_TWS;
        else if (ch == CH_PLUS) t.ph = PH_TDIG;
        else if (is_dec(ch)) begin
          t.acc = acc_prefix(8'd0, ch);
          t.ph = PH_TDIG;
        end else begin
          t.acc = 8'd0;
          t.ph = PH_DONE;
        end
      end
      PH_TDIG: begin
        if (is_dec(ch)) t.acc = acc_prefix(acc, ch);
        else t.ph = PH_DONE;
      end
      default: t.ph = ph;
    endcase
    return t;
  endfunction

  always_comb begin
    tail_t       t4;
    tail_t       t6;
    logic [11:0] v4v;
    logic [20:0] v6v;
    logic [4:0]  h;
    logic [3:0]  fc;
    logic [3:0]  bc;
    logic [4:0]  tot;
    logic        stop;
    logic        early_fail;
    phase_t      nxt_ph;

    nxt = cur;
    t4 = '0;
    t6 = '0;
    v4v = '0;
    v6v = '0;
    h = hex_val(c);
    fc = cur.v6_fcnt;
    bc = cur.v6_bcnt;
    tot = '0;
    stop = 1'b0;
    early_fail = 1'b0;
    nxt_ph = PH_PARSE;

    // IPv4 side
    if (cur.v4_ph != PH_PARSE) begin
      t4 = tail_step(cur.v4_ph, cur.v4_pre, c);
      nxt.v4_ph = t4.ph;
      nxt.v4_pre = t4.acc;
    end else if (is_dec(c)) begin
      if (cur.v4_acc <= 9'd255) begin
        v4v = {3'b0, cur.v4_acc} * 12'd10 + {8'b0, c[3:0]};
        nxt.v4_acc = (v4v > 12'd255) ? 9'd256 : v4v[8:0];
      end
    end else if (cur.v4_acc > 9'd255 || cur.v4_cnt > 3'd3) begin
      nxt.v4_ph = PH_FAIL;
    end else begin
      nxt.v4_octets = cur.v4_octets |
                      ({24'b0, cur.v4_acc[7:0]} << {~cur.v4_cnt[1:0], 3'b000});
      nxt.v4_cnt = cur.v4_cnt + 3'd1;
      if (c != CH_DOT || l1 == CH_DOT) begin
        t4 = tail_step(PH_TSTART, cur.v4_pre, c);
        nxt.v4_ph = t4.ph;
        nxt.v4_pre = t4.acc;
      end else begin
        nxt.v4_acc = 9'd0;
        if (nxt.v4_cnt == 3'd4) nxt.v4_ph = PH_TSTART;
      end
    end

    // IPv6 side
    if (cur.v6_ph == PH_SKIP) begin
      nxt.v6_ph = PH_PARSE;
    end else if (cur.v6_ph != PH_PARSE) begin
      t6 = tail_step(cur.v6_ph, cur.v6_pre, c);
      nxt.v6_ph = t6.ph;
      nxt.v6_pre = t6.acc;
    end else if (h[4]) begin
      if (cur.v6_acc <= 17'd65535) begin
        v6v = {4'b0, cur.v6_acc} * 21'd16 + {17'b0, h[3:0]};
        nxt.v6_acc = (v6v > 21'd65535) ? 17'd65536 : v6v[16:0];
      end
    end else if (cur.v6_acc > 17'd65535 ||
                 ({1'b0, cur.v6_fcnt} + {1'b0, cur.v6_bcnt}) >= 5'd8) begin
      nxt.v6_ph = PH_FAIL;
    end else begin
      if (!cur.first) begin
        if (cur.v6_dc) begin
          nxt.v6_back = {cur.v6_back[6:0], cur.v6_acc[15:0]};
          bc = bc + 4'd1;
        end else begin
          nxt.v6_front[fc[2:0]] = cur.v6_acc[15:0];
          fc = fc + 4'd1;
        end
      end
      nxt.v6_fcnt = fc;
      nxt.v6_bcnt = bc;
      tot = {1'b0, fc} + {1'b0, bc};
      stop = (c != CH_COLON) || (tot == 5'd8);
      if (!stop && l1 == CH_COLON) begin
        if (cur.v6_dc || l2 == CH_COLON) stop = 1'b1;
        else begin
          nxt.v6_dc = 1'b1;
          nxt_ph = PH_SKIP;
        end
      end else if (!stop && cur.first) begin
        early_fail = 1'b1;
      end
      if (early_fail) begin
        nxt.v6_ph = PH_FAIL;
      end else if (stop) begin
        if ((nxt.v6_dc && tot == 5'd8) || (!nxt.v6_dc && tot < 5'd8)) begin
          nxt.v6_ph = PH_FAIL;
        end else begin
          t6 = tail_step(PH_TSTART, cur.v6_pre, c);
          nxt.v6_ph = t6.ph;
          nxt.v6_pre = t6.acc;
        end
      end else begin
        nxt.v6_acc = 17'd0;
        nxt.v6_ph = nxt_ph;
      end
    end

    nxt.first = 1'b0;
  end

endmodule
`default_nettype wire

// ===== bench/ipp_result_checker.sv =====
`timescale 1ns / 1ps
module ipp_result_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  input  logic             text_stall,
  input  ipp_pkg::text_t   text,
  input  logic             result_valid,
  input  logic             result_stall,
  input  ipp_pkg::result_t result,
  output int               fails,
  output int               pending
);
  import ipp_pkg::*;

  // Parser state mirrored from the block.
  byte unsigned la0, la1;
  int           la_cnt;
  bit           saw_colon, saw_dot;
  logic [31:0]  v4_oct;
  int           v4_cnt, v4_acc, v4_pre;
  phase_t       v4_ph;
  logic [15:0]  v6_front [8];
  logic [15:0]  v6_back [8];
  int           v6_fc, v6_bc, v6_acc, v6_pre;
  bit           v6_dc, first_char;
  phase_t       v6_ph;

  result_t      awaited_results [$];

  assign pending = awaited_results.size();

  function automatic bit is_dec(byte unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hex_val(byte unsigned c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic bit is_space(byte unsigned c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic int prefix_digit(int acc, byte unsigned c);
    int v;
    v = acc * 10 + (c - "0");
    return v > 255 ? 255 : v;
  endfunction

  // Text after the address: slash, blanks, an optional plus sign, then digits read like atoi.
  function automatic phase_t prefix_phase(phase_t ph, ref int acc, input byte unsigned c);
    case (ph)
      PH_TSTART: begin
        if (c == CH_NUL) begin
          acc = 0;
          return PH_DONE;
        end
        return c == CH_SLASH ? PH_TWS : PH_FAIL;
      end
      PH_TWS: begin
        if (is_space(c)) return PH_TWS;
        if (c == CH_PLUS) return PH_TDIG;
        if (is_dec(c)) begin
          acc = prefix_digit(0, c);
          return PH_TDIG;
        end
        acc = 0;
        return PH_DONE;
      end
      PH_TDIG: begin
        if (is_dec(c)) begin
          acc = prefix_digit(acc, c);
          return PH_TDIG;
        end
        return PH_DONE;
      end
      default: return ph;
    endcase
  endfunction

  function automatic void clear_parser();
    la0 = 0; la1 = 0; la_cnt = 0;
    saw_colon = 0; saw_dot = 0;
    v4_oct = 0; v4_cnt = 0; v4_acc = 0; v4_pre = 0; v4_ph = PH_PARSE;
    foreach (v6_front[i]) begin
      v6_front[i] = 0;
      v6_back[i] = 0;
    end
    v6_fc = 0; v6_bc = 0; v6_acc = 0; v6_pre = 0; v6_dc = 0; v6_ph = PH_PARSE;
    first_char = 1;
  endfunction

  function automatic void v4_char(byte unsigned c, byte unsigned l1);
    int v;
    if (v4_ph != PH_PARSE) begin
      v4_ph = prefix_phase(v4_ph, v4_pre, c);
      return;
    end
    if (is_dec(c)) begin
      if (v4_acc <= 255) begin
        v = v4_acc * 10 + (c - "0");
        v4_acc = v > 255 ? 256 : v;
      end
      return;
    end
    if (v4_acc > 255 || v4_cnt > 3) begin
      v4_ph = PH_FAIL;
      return;
    end
    v4_oct |= 32'(v4_acc & 255) << (8 * (3 - v4_cnt));
    v4_cnt++;
    if (c != CH_DOT || l1 == CH_DOT) begin
      v4_ph = prefix_phase(PH_TSTART, v4_pre, c);
      return;
    end
    v4_acc = 0;
    if (v4_cnt == 4) v4_ph = PH_TSTART;
  endfunction

  function automatic void v6_char(byte unsigned c, byte unsigned l1, byte unsigned l2);
    bit     stop;
    phase_t nxt;
    int     h, v, total;
    nxt = PH_PARSE;
    if (v6_ph == PH_SKIP) begin
      v6_ph = PH_PARSE;
      return;
    end
    if (v6_ph != PH_PARSE) begin
      v6_ph = prefix_phase(v6_ph, v6_pre, c);
      return;
    end
    h = hex_val(c);
    if (h >= 0) begin
      if (v6_acc <= 65535) begin
        v = v6_acc * 16 + h;
        v6_acc = v > 65535 ? 65536 : v;
      end
      return;
    end
    if (v6_acc > 65535 || v6_fc + v6_bc >= 8) begin
      v6_ph = PH_FAIL;
      return;
    end
    if (!first_char) begin
      if (v6_dc) begin
        v6_back[v6_bc & 7] = 16'(v6_acc);
        v6_bc++;
      end else begin
        v6_front[v6_fc & 7] = 16'(v6_acc);
        v6_fc++;
      end
    end
    stop = (c != CH_COLON) || (v6_fc + v6_bc == 8);
    if (!stop && l1 == CH_COLON) begin
      if (v6_dc || l2 == CH_COLON) stop = 1;
      else begin
        v6_dc = 1;
        nxt = PH_SKIP;
      end
    end else if (!stop && first_char) begin
      v6_ph = PH_FAIL;
      return;
    end
    if (stop) begin
      total = v6_fc + v6_bc;
      if ((v6_dc && total == 8) || (!v6_dc && total < 8)) v6_ph = PH_FAIL;
      else v6_ph = prefix_phase(PH_TSTART, v6_pre, c);
      return;
    end
    v6_acc = 0;
    v6_ph = nxt;
  endfunction

  function automatic void parse_char(byte unsigned c, byte unsigned l1, byte unsigned l2);
    v4_char(c, l1);
    v6_char(c, l1, l2);
    first_char = 0;
  endfunction

  // Takes one character; returns 1 with the parse result on the final one.
  function automatic bit take_char(byte unsigned c, bit last, output result_t r);
    byte unsigned s [6];
    logic [15:0]  g [8];
    int           k, maxp, pre;
    r = '0;
    if (c == CH_COLON) saw_colon = 1;
    if (c == CH_DOT) saw_dot = 1;
    k = la_cnt;
    if (!last) begin
      if (k == 2) begin
        parse_char(la0, la1, c);
        la0 = la1;
        la1 = c;
      end else begin
        if (k == 0) la0 = c;
        else la1 = c;
        la_cnt = k + 1;
      end
      return 0;
    end
    foreach (s[j]) s[j] = 0;
    if (k > 0) s[0] = la0;
    if (k > 1) s[1] = la1;
    s[k] = c;
    for (int j = 0; j < k + 2; j++) parse_char(s[j], s[j + 1], s[j + 2]);
    pre = 0;
    if (saw_colon) begin
      maxp = V6_MAX_PREFIX;
      if (v6_ph == PH_DONE) begin
        foreach (g[j]) g[j] = 0;
        for (int j = 0; j < (v6_fc > 8 ? 8 : v6_fc); j++) g[j] = v6_front[j];
        for (int j = 0; j < (v6_bc > 8 ? 8 : v6_bc); j++)
          g[8 - (v6_bc > 8 ? 8 : v6_bc) + j] = v6_back[j];
        r.address_high = {g[0], g[1], g[2], g[3]};
        r.address_low  = {g[4], g[5], g[6], g[7]};
        r.is_ipv6 = 1;
        r.valid_res = 1;
        pre = v6_pre;
      end
    end else begin
      maxp = V4_MAX_PREFIX;
      if (saw_dot && v4_ph == PH_DONE) begin
        r.address_high = {v4_oct, 32'h0};
        r.valid_res = 1;
        pre = v4_pre;
      end
    end
    if (r.valid_res) r.prefix_length = 8'((pre < 1 || pre > maxp) ? maxp : pre);
    clear_parser();
    return 1;
  endfunction

  initial begin
    fails = 0;
    clear_parser();
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      clear_parser();
    end else begin
      if (text_valid && !text_stall) begin
        if (take_char(text.character, text.end_of_text, want)) awaited_results.push_back(want);
      end
      if (result_valid && !result_stall) begin
        got = result;
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
            fails++;
          end
          if (got.is_ipv6 !== want.is_ipv6) begin
            $error("is_ipv6: expected %0d, got %0d", want.is_ipv6, got.is_ipv6);
            fails++;
          end
          if (got.address_high !== want.address_high) begin
            $error("address_high: expected %h, got %h", want.address_high, got.address_high);
            fails++;
          end
          if (got.address_low !== want.address_low) begin
            $error("address_low: expected %h, got %h", want.address_low, got.address_low);
            fails++;
          end
          if (got.prefix_length !== want.prefix_length) begin
            $error("prefix_length: expected %0d, got %0d", want.prefix_length,
                   got.prefix_length);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_ip_address_text_parser.sv =====
`timescale 1ns / 1ps
module tb_ip_address_text_parser;
  import ipp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam string PUNCT = ".:/0123456789abcdefABCDEF +-\t";

  logic    clk = 0;
  logic    rst = 1;
  logic    text_valid = 0;
  logic    text_stall;
  text_t   text = '0;
  logic    result_valid;
  logic    result_stall = 0;
  result_t result;

  int fails, pending;
  int idle_pct = 0, stall_pct = 0;
  int cycles = 0, chars_sent = 0, strings_sent = 0;

  ip_address_text_parser dut (
    .clk(clk), .rst(rst),
    .text_valid(text_valid), .text_stall(text_stall), .text(text),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  ipp_result_checker u_checker (
    .clk(clk), .rst(rst),
    .text_valid(text_valid), .text_stall(text_stall), .text(text),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fails(fails), .pending(pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ip_address_text_parser: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  task automatic put_char(byte unsigned c, bit last);
    while ($urandom_range(99) < idle_pct) begin
      text_valid <= 0;
      @(posedge clk);
    end
    text_valid <= 1;
    text <= '{character: c, end_of_text: last};
    do @(posedge clk); while (text_stall);
    chars_sent++;
  endtask

  task automatic send_text(byte unsigned q [$]);
    foreach (q[i]) put_char(q[i], i == q.size() - 1);
    strings_sent++;
  endtask

  function automatic void add_str(ref byte unsigned q [$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_prefix(ref byte unsigned q [$]);
    int r;
    q.push_back(CH_SLASH);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      q.push_back($urandom_range(1) ? 8'h20 : 8'h09);
    r = $urandom_range(9);
    if (r == 0) q.push_back(CH_PLUS);
    else if (r == 1) q.push_back(CH_MINUS);
    if ($urandom_range(9) != 0)
      add_str(q, $sformatf("%0d", $urandom_range(7) == 0 ? $urandom_range(129, 999)
                                                          : $urandom_range(0, 129)));
    if ($urandom_range(6) == 0) q.push_back(PUNCT[$urandom_range(PUNCT.len() - 1)]);
  endfunction

  function automatic void make_v4(ref byte unsigned q [$]);
    int n, r;
    n = $urandom_range(9) < 7 ? 4 : $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if (i > 0) q.push_back(CH_DOT);
      r = $urandom_range(19);
      if (r == 0) add_str(q, $sformatf("%0d", $urandom_range(256, 999)));
      else if (r == 1) ;
      else if (r == 2) add_str(q, $sformatf("0%0d", $urandom_range(0, 99)));
      else add_str(q, $sformatf("%0d", $urandom_range(0, 255)));
    end
    if ($urandom_range(1)) add_prefix(q);
  endfunction

  function automatic void add_group(ref byte unsigned q [$]);
    string s;
    s = $urandom_range(19) == 0
        ? $sformatf("%0h", $urandom_range(32'h10000, 32'hFFFFF))
        : $sformatf("%0h", $urandom_range(0, (1 << (4 * $urandom_range(1, 4))) - 1));
    if ($urandom_range(1)) s = s.toupper();
    add_str(q, s);
  endfunction

  function automatic void make_v6(ref byte unsigned q [$]);
    int f, b;
    if ($urandom_range(1)) begin
      f = $urandom_range(0, 7);
      b = $urandom_range(0, 7 - f);
      if ($urandom_range(9) == 0) b++;
      for (int i = 0; i < f; i++) begin
        if (i > 0) q.push_back(CH_COLON);
        add_group(q);
      end
      add_str(q, "::");
      for (int i = 0; i < b; i++) begin
        if (i > 0) q.push_back(CH_COLON);
        add_group(q);
      end
    end else begin
      f = $urandom_range(9) == 0 ? $urandom_range(6, 9) : 8;
      for (int i = 0; i < f; i++) begin
        if (i > 0) q.push_back(CH_COLON);
        add_group(q);
      end
    end
    if ($urandom_range(1)) add_prefix(q);
  endfunction

  function automatic byte unsigned any_char();
    return $urandom_range(1) ? PUNCT[$urandom_range(PUNCT.len() - 1)]
                             : 8'($urandom_range(1, 255));
  endfunction

  function automatic void make_random(ref byte unsigned q [$]);
    int r, p;
    r = $urandom_range(99);
    if (r < 10) begin
      repeat ($urandom_range(1, 10)) q.push_back(any_char());
      return;
    end
    if (r < 50) make_v4(q);
    else make_v6(q);
    // A share of generated text gets one character replaced, deleted or inserted.
    if (r % 5 == 0 && q.size() > 0) begin
      p = $urandom_range(q.size() - 1);
      case ($urandom_range(2))
        0: q[p] = any_char();
        1: if (q.size() > 1) q.delete(p);
        default: q.insert(p, any_char());
      endcase
    end
  endfunction

  initial begin
    string          directed [] = '{"1.2.3.4/8", "256.", "::", "x", "F::/ -", "9.9"};
    byte unsigned   q [$];
    repeat (3) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) begin
      q.delete();
      add_str(q, directed[i]);
      send_text(q);
    end
    while (chars_sent < 750 || strings_sent < 60) begin
      case (chars_sent * 4 / 800)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      q.delete();
      make_random(q);
      send_text(q);
    end
    text_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d address strings, %0d characters: IPv4, IPv6, prefixes and noise,",
             strings_sent, chars_sent);
    $display("under phases of free flow, sender gaps, receiver stalls and both.");
    if (fails == 0) $display("tb_ip_address_text_parser: done, clean");
    else $display("tb_ip_address_text_parser: done, errors");
    $finish;
  end

endmodule
